[rtl/pgsf_pkg.sv]
`default_nettype none
package pgsf_pkg;

  localparam int CMD_W     = 2;
  localparam int SAMPLE_W  = 8;
  localparam int COUNT_W   = 11;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SKIP  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  localparam logic [2:0] ADDR_START_THRESHOLD = 3'd0;

  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 11'd512;

  typedef struct packed {
    logic                       running;
    logic        [COUNT_W-1:0]  free_space;
    logic        [COUNT_W-1:0]  fill_count;
    logic        [COUNT_W-1:0]  skipped;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       ok;
  } result_t;

endpackage
`default_nettype wire

[rtl/prefill_gated_sample_fifo.sv]
// Prefill-gated ring FIFO of signed 8-bit audio samples.
// Commands arrive on the s_* stream: s_tuser carries the command (push, pop,
// skip, clear), s_tdata the sample and the skip count. Every command gives
// exactly one result transfer on the m_* stream: m_tuser is the ok flag,
// m_tdata the popped sample, the skipped count, fill count, free space and
// the running flag. Pops and skips are refused until a push brings the fill
// count up to start_threshold (APB register at address 0); the FIFO stops
// again when it runs empty or on a clear command.
// A command first enters the input register; then it is executed against the
// state and the sample memory and the result is registered. One command is
// taken every cycle while the receiver accepts results; the sample memory has
// one write port and one registered read port that always holds the entry at
// the read pointer, with a write bypass. When the receiver stalls, the result
// and input registers hold and s_tready drops once the input register is
// full; nothing is lost. Reset (rst, synchronous) empties the FIFO, stops it,
// clears both stages and sets start_threshold to 512. The sample memory is not
// cleared; no command can read an unwritten entry.
`default_nettype none
module prefill_gated_sample_fifo
  import pgsf_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [23:0] s_tdata,   // sample_in[7:0], skip_request[18:8], zero pad
  input  wire logic [1:0]  s_tuser,   // cmd[1:0]
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [47:0] m_tdata,   // sample_out[7:0], skipped[18:8], fill_count[29:19],
                                      // free_space[40:30], running[41], zero pad
  output      logic        m_tuser,   // ok[0]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int HW = $clog2(DEPTH + 1);
  localparam int SW = PW + 1;
  localparam int CW = (HW > COUNT_W) ? HW : COUNT_W;

  // configuration
  logic [COUNT_W-1:0] start_threshold;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_START_THRESHOLD[2]) ?
                  {{(32-COUNT_W){1'b0}}, start_threshold} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == ADDR_START_THRESHOLD[2])) begin
      start_threshold <= pwdata[COUNT_W-1:0];
    end
  end

  // input register
  logic                       in_valid;
  logic [CMD_W-1:0]           in_cmd;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [COUNT_W-1:0]         in_request;
  logic                       out_valid;
  result_t                    out_result;
  logic                       advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd     <= s_tuser;
      in_sample  <= s_tdata[SAMPLE_W-1:0];
      in_request <= s_tdata[SAMPLE_W+COUNT_W-1:SAMPLE_W];
    end
  end

  // FIFO state
  logic [PW-1:0] write_pointer, write_pointer_next;
  logic [PW-1:0] read_pointer, read_pointer_next;
  logic [HW-1:0] held_count, held_count_next;
  logic          run_flag, run_flag_next;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data;
  logic [PW-1:0]              rd_addr;
  logic                       wr_en;

  logic [HW-1:0] skip_n;
  logic [CW-1:0] request_c;
  logic [CW-1:0] held_c;
  logic [SW-1:0] skip_sum;
  result_t       result;

  always_comb begin
    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    held_count_next    = held_count;
    run_flag_next      = run_flag;
    wr_en              = 1'b0;
    request_c          = CW'(in_request);
    held_c             = CW'(held_count);
    skip_n             = (request_c < held_c) ? HW'(request_c) : held_count;
    skip_sum           = SW'(read_pointer) + SW'(skip_n);
    if (skip_sum >= SW'(DEPTH)) begin
      skip_sum = skip_sum - SW'(DEPTH);
    end
    result            = '0;

    if (advance) begin
      unique case (in_cmd)
        CMD_PUSH: begin
          if (held_count < HW'(DEPTH)) begin
            wr_en              = 1'b1;
            write_pointer_next = (write_pointer == PW'(DEPTH - 1)) ? '0 : write_pointer + 1'b1;
            held_count_next    = held_count + 1'b1;
            if (CW'(held_count_next) >= CW'(start_threshold)) begin
              run_flag_next = 1'b1;
            end
            result.ok = 1'b1;
          end
        end
        CMD_POP: begin
          if (run_flag && (held_count != '0)) begin
            result.sample_out = rd_data;
            read_pointer_next = (read_pointer == PW'(DEPTH - 1)) ? '0 : read_pointer + 1'b1;
            held_count_next   = held_count - 1'b1;
            if (held_count_next == '0) begin
              run_flag_next = 1'b0;
            end
            result.ok = 1'b1;
          end
        end
        CMD_SKIP: begin
          if (run_flag) begin
            read_pointer_next = skip_sum[PW-1:0];
            held_count_next   = held_count - skip_n;
            if (held_count_next == '0) begin
              run_flag_next = 1'b0;
            end
            result.skipped = COUNT_W'(CW'(skip_n));
          end
        end
        CMD_CLEAR: begin
          write_pointer_next = read_pointer;
          held_count_next    = '0;
          run_flag_next      = 1'b0;
        end
      endcase
    end

    result.fill_count = COUNT_W'(CW'(held_count_next));
    result.free_space = COUNT_W'(CW'(DEPTH) - CW'(held_count_next));
    result.running    = run_flag_next;
    rd_addr           = rst ? '0 : read_pointer_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      held_count    <= '0;
      run_flag      <= 1'b0;
    end else begin
      write_pointer <= write_pointer_next;
      read_pointer  <= read_pointer_next;
      held_count    <= held_count_next;
      run_flag      <= run_flag_next;
    end
  end

  // rd_data always holds the entry at read_pointer; bypass covers a push
  // into the slot about to be read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[write_pointer] <= in_sample;
    end
    if (wr_en && (write_pointer == rd_addr)) begin
      rd_data <= in_sample;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_result.ok;
  assign m_tdata  = {6'd0, out_result.running, out_result.free_space, out_result.fill_count,
                     out_result.skipped, out_result.sample_out};

endmodule
`default_nettype wire
